### rtl/core/i2cme_pkg.sv
// Shared types, constants and the phase drive function of the I2C master byte engine.
package i2cme_pkg;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam int unsigned TICK_W       = 16;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned IN_TDATA_W   = 16;
    localparam int unsigned OUT_TDATA_W  = 16;
    localparam logic [IDX_W-1:0] START_PHASES = 5'd3;
    localparam logic [IDX_W-1:0] STOP_PHASES  = 5'd2;
    localparam logic [IDX_W-1:0] BYTE_PHASES  = 5'd18;
    localparam logic [IDX_W-1:0] ACK_PHASE    = 5'd16;

    typedef struct packed {
        logic              scl;
        logic              sda;
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [TICK_W-1:0] ticks;
        logic [7:0]        shift;
        logic              ack_bit;
        logic [7:0]        last_read;
        logic              ack_to_send;
    } eng_state_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_sample;
    } req_t;

    typedef struct packed {
        logic       rejected;
        logic [7:0] read_data;
        logic       ack_received;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } res_t;

    localparam eng_state_t STATE_RESET = '{
        scl: 1'b1, sda: 1'b1, op: OP_NONE, idx: '0, ticks: '0,
        shift: '0, ack_bit: 1'b0, last_read: '0, ack_to_send: 1'b0
    };

    // Returns {scl, sda} for the given phase of a running command.
    function automatic logic [1:0] phase_drive(input op_t op, input logic [IDX_W-1:0] idx,
                                               input logic [7:0] shift, input logic ack_tx,
                                               input logic [1:0] cur);
        logic [1:0] d;
        d = cur;
        unique case (op)
            OP_START: d = {(idx < 5'd2), (idx == 5'd0)};
            OP_STOP:  d = {1'b1, (idx != 5'd0)};
            OP_WRITE: d = {~idx[0], (idx < ACK_PHASE) ? shift[7] : 1'b1};
            OP_READ:  d = {~idx[0], (idx < ACK_PHASE) ? 1'b1 : ~ack_tx};
            default:  d = cur;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/i2cme_step.sv
// Next-state and result logic for one tick of the I2C master byte engine.
module i2cme_step
    import i2cme_pkg::*;
(
    input  eng_state_t        cur,
    input  req_t              req,
    input  logic [TICK_W-1:0] half_period_ticks,
    output eng_state_t        nxt,
    output res_t              res
);

    logic              is_cmd;
    logic              done;
    logic              rej;
    logic [TICK_W-1:0] ticks_inc;
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  phases;
    logic [1:0]        drv;
    op_t               req_op;

    assign req_op = op_t'(req.operation);

    always_comb begin
        nxt       = cur;
        done      = 1'b0;
        rej       = 1'b0;
        is_cmd    = (req.operation >= OP_START) && (req.operation <= OP_READ);
        ticks_inc = cur.ticks + 16'd1;
        idx_inc   = cur.idx + 5'd1;
        drv       = {cur.scl, cur.sda};
        unique case (cur.op)
            OP_START: phases = START_PHASES;
            OP_STOP:  phases = STOP_PHASES;
            default:  phases = BYTE_PHASES;
        endcase
        if (cur.op != OP_NONE) begin
            rej       = is_cmd;
            nxt.ticks = ticks_inc;
            if (ticks_inc >= half_period_ticks) begin
                nxt.ticks = '0;
                if (cur.op == OP_WRITE) begin
                    if ((cur.idx < ACK_PHASE) && cur.idx[0]) begin
                        nxt.shift = {cur.shift[6:0], 1'b0};
                    end else if (cur.idx == ACK_PHASE) begin
                        nxt.ack_bit = ~req.sda_sample;
                    end
                end else if (cur.op == OP_READ) begin
                    if ((cur.idx < ACK_PHASE) && !cur.idx[0]) begin
                        nxt.shift = {cur.shift[6:0], req.sda_sample};
                    end
                end
                nxt.idx = idx_inc;
                if (idx_inc >= phases) begin
                    if (cur.op == OP_READ) begin
                        nxt.last_read = nxt.shift;
                        nxt.sda       = 1'b1;
                    end
                    nxt.op  = OP_NONE;
                    nxt.idx = '0;
                    done    = 1'b1;
                end else begin
                    drv     = phase_drive(cur.op, idx_inc, nxt.shift, cur.ack_to_send,
                                          {cur.scl, cur.sda});
                    nxt.scl = drv[1];
                    nxt.sda = drv[0];
                end
            end
        end else if (is_cmd) begin
            nxt.op    = req_op;
            nxt.idx   = '0;
            nxt.ticks = '0;
            if (req_op == OP_WRITE) begin
                nxt.shift = req.data_byte;
            end else if (req_op == OP_READ) begin
                nxt.shift       = '0;
                nxt.ack_to_send = req.send_ack;
            end
            drv     = phase_drive(req_op, 5'd0, nxt.shift, nxt.ack_to_send,
                                  {cur.scl, cur.sda});
            nxt.scl = drv[1];
            nxt.sda = drv[0];
        end
    end

    assign res.scl_level    = nxt.scl;
    assign res.sda_level    = nxt.sda;
    assign res.busy_res     = (nxt.op != OP_NONE);
    assign res.done_res     = done;
    assign res.ack_received = nxt.ack_bit;
    assign res.read_data    = nxt.last_read;
    assign res.rejected     = rej;

endmodule

### rtl/core/i2c_master_byte_engine_top.sv
// Top level of the I2C master byte engine: stream ports, state and result registers.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tick request (operation, data_byte, send_ack, sda_sample)
// m_       out  m_tvalid/m_tready  one result per request (bus drives and status)
// cfg_     in   cfg_wr_en          half_period_ticks
//
// Each request is processed in the cycle it is accepted, and its result is
// registered, so while m_tready is high one request per cycle is sustained.
// The request logic is the single-pass step between engine state and result registers.
// s_tready is high whenever the result register is empty or being drained.
// Reset releases both lines, idles the engine and sets half_period_ticks to one.
module i2c_master_byte_engine_top
    import i2cme_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: operation[2:0], data_byte[10:3], send_ack[11], sda_sample[12].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: scl_level[0], sda_level[1], busy_res[2], done_res[3],
    // ack_received[4], read_data[12:5], rejected[13].
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [TICK_W-1:0]      cfg_wr_data
);

    eng_state_t        state_reg;
    eng_state_t        state_next;
    res_t              res_reg;
    res_t              res_next;
    logic              m_tvalid_reg;
    logic [TICK_W-1:0] half_period_reg;
    req_t              req;
    logic              s_accept;

    assign req.operation  = s_tdata[2:0];
    assign req.data_byte  = s_tdata[10:3];
    assign req.send_ack   = s_tdata[11];
    assign req.sda_sample = s_tdata[12];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    i2cme_step u_step (
        .cur               (state_reg),
        .req               (req),
        .half_period_ticks (half_period_reg),
        .nxt               (state_next),
        .res               (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= STATE_RESET;
            m_tvalid_reg    <= 1'b0;
            half_period_reg <= 16'd1;
        end else begin
            if (cfg_wr_en) begin
                half_period_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, res_reg};

endmodule

### verif/testbench.sv
// Self-checking testbench for the I2C master byte engine: stream stimulus, prediction and checks.
`timescale 1ns / 100ps

import i2cme_pkg::*;

class bus_phase_scoreboard;
    logic [TICK_W-1:0] half_period;
    logic              scl;
    logic              sda;
    op_t               running;
    logic [IDX_W-1:0]  phase;
    logic [TICK_W-1:0] phase_ticks;
    logic [7:0]        shift_reg;
    logic              ack_bit;
    logic              ack_tx;
    logic [7:0]        last_read;
    res_t              expected_drives[$];
    int                errors;
    int                printed;
    int                requests;
    int                checked;
    int                finished;
    int                rejects;

    function new();
        half_period = 16'd1;
        scl = 1'b1;
        sda = 1'b1;
        running = OP_NONE;
        phase = '0;
        phase_ticks = '0;
        shift_reg = '0;
        ack_bit = 1'b0;
        ack_tx = 1'b0;
        last_read = '0;
        errors = 0;
        printed = 0;
        requests = 0;
        checked = 0;
        finished = 0;
        rejects = 0;
    endfunction

    function void set_half(logic [TICK_W-1:0] value);
        half_period = value;
    endfunction

    function bit busy();
        return running != OP_NONE;
    endfunction

    function int pending();
        return expected_drives.size();
    endfunction

    function logic [IDX_W-1:0] phases_of(op_t op);
        if (op == OP_START) return START_PHASES;
        if (op == OP_STOP) return STOP_PHASES;
        return BYTE_PHASES;
    endfunction

    function void drive_phase();
        case (running)
            OP_START: begin
                scl = (phase < 5'd2);
                sda = (phase == 5'd0);
            end
            OP_STOP: begin
                scl = 1'b1;
                sda = (phase != 5'd0);
            end
            OP_WRITE: begin
                scl = ~phase[0];
                sda = (phase < ACK_PHASE) ? shift_reg[7] : 1'b1;
            end
            OP_READ: begin
                scl = ~phase[0];
                sda = (phase < ACK_PHASE) ? 1'b1 : ~ack_tx;
            end
            default: ;
        endcase
    endfunction

    function void note_request(logic [2:0] op, logic [7:0] data, logic sack, logic sda_in);
        res_t             r;
        logic [IDX_W-1:0] idx;
        bit               is_cmd;
        is_cmd = (op >= OP_START) && (op <= OP_READ);
        r = '0;
        requests++;
        if (running != OP_NONE) begin
            r.rejected = is_cmd;
            phase_ticks = phase_ticks + 16'd1;
            if (phase_ticks >= half_period) begin
                idx = phase;
                phase_ticks = '0;
                if (running == OP_WRITE) begin
                    if (idx < ACK_PHASE && idx[0])
                        shift_reg = shift_reg << 1;
                    else if (idx == ACK_PHASE)
                        ack_bit = ~sda_in;
                end else if (running == OP_READ && idx < ACK_PHASE && !idx[0]) begin
                    shift_reg = {shift_reg[6:0], sda_in};
                end
                phase = idx + 5'd1;
                if (phase >= phases_of(running)) begin
                    if (running == OP_READ) begin
                        last_read = shift_reg;
                        sda = 1'b1;
                    end
                    running = OP_NONE;
                    phase = '0;
                    r.done_res = 1'b1;
                    finished++;
                end else begin
                    drive_phase();
                end
            end
        end else if (is_cmd) begin
            running = op_t'(op);
            phase = '0;
            phase_ticks = '0;
            if (running == OP_WRITE) begin
                shift_reg = data;
            end else if (running == OP_READ) begin
                shift_reg = '0;
                ack_tx = sack;
            end
            drive_phase();
        end
        if (r.rejected) rejects++;
        r.scl_level = scl;
        r.sda_level = sda;
        r.busy_res = (running != OP_NONE);
        r.ack_received = ack_bit;
        r.read_data = last_read;
        expected_drives.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            if (printed < 40) begin
                printed++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
        res_t want;
        res_t got;
        if (expected_drives.size() == 0) begin
            errors++;
            $display("%0t: result 0x%0h arrived with no request outstanding, expected none",
                     $time, tdata);
            return;
        end
        want = expected_drives.pop_front();
        got = res_t'(tdata[13:0]);
        checked++;
        compare_field("scl_level", want.scl_level, got.scl_level);
        compare_field("sda_level", want.sda_level, got.sda_level);
        compare_field("busy_res", want.busy_res, got.busy_res);
        compare_field("done_res", want.done_res, got.done_res);
        compare_field("ack_received", want.ack_received, got.ack_received);
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("rejected", want.rejected, got.rejected);
        compare_field("padding", 0, tdata[OUT_TDATA_W-1:14]);
    endfunction
endclass

module testbench;

    localparam int IDLE_LIMIT = 5000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [TICK_W-1:0]      cfg_wr_data = '0;

    logic quiet = 1'b0;
    logic stall_go = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;
    int   settings_used = 0;

    bus_phase_scoreboard sb = new();

    i2c_master_byte_engine_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // The receiver stalls at random, or for one long stretch when asked.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_go != stall_seen) begin
            stall_seen = stall_go;
            stall_left = 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timed out after %0d cycles without a handshake.", IDLE_LIMIT);
        $display("i2c_master_byte_engine_top regression: fail");
        $finish;
    end

    task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic sack,
                             input logic sda_in);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, sda_in, sack, data, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, data, sack, sda_in);
    endtask

    task automatic finish_command(input int sda_level, input int noise_pct);
        logic [2:0] op;
        while (sb.busy()) begin
            op = OP_NONE;
            if ($urandom_range(0, 99) < noise_pct)
                op = 3'($urandom_range(1, 7));
            send_tick(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      (sda_level < 0) ? 1'($urandom_range(0, 1)) : sda_level[0]);
        end
    endtask

    task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic sack,
                               input int sda_level, input int noise_pct);
        send_tick(op, data, sack, 1'($urandom_range(0, 1)));
        finish_command(sda_level, noise_pct);
    endtask

    task automatic set_half_period(input logic [TICK_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_half(value);
        settings_used++;
    endtask

    initial begin
        int k;
        int base;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        run_command(OP_START, 8'h00, 1'b0, -1, 0);
        run_command(OP_WRITE, 8'hFF, 1'b0, 0, 0);
        run_command(OP_WRITE, 8'h00, 1'b0, 1, 0);
        run_command(OP_READ, 8'h00, 1'b1, 1, 0);
        run_command(OP_READ, 8'hFF, 1'b0, 0, 0);
        send_tick(OP_WRITE, 8'hA5, 1'b0, 1'b0);
        send_tick(OP_START, 8'h00, 1'b1, 1'b1);
        send_tick(OP_STOP, 8'hFF, 1'b0, 1'b0);
        send_tick(OP_READ, 8'h00, 1'b1, 1'b1);
        send_tick(OP_WRITE, 8'hFF, 1'b1, 1'b0);
        send_tick(3'd5, 8'h00, 1'b0, 1'b1);
        send_tick(3'd7, 8'hFF, 1'b1, 1'b0);
        finish_command(-1, 0);
        run_command(OP_STOP, 8'h00, 1'b0, -1, 0);
        send_tick(3'd5, 8'hFF, 1'b1, 1'b1);
        send_tick(3'd6, 8'h00, 1'b0, 1'b0);
        send_tick(3'd7, 8'hFF, 1'b1, 1'b1);

        // A zero half period must behave like one tick per phase.
        set_half_period(16'd0);
        run_command(OP_START, 8'h00, 1'b0, -1, 0);
        run_command(OP_WRITE, 8'h5A, 1'b0, -1, 0);
        run_command(OP_READ, 8'h00, 1'b1, -1, 0);
        run_command(OP_STOP, 8'h00, 1'b0, -1, 0);

        // A long phase is cut short when the length changes mid-command.
        set_half_period(16'hFFFF);
        send_tick(OP_START, 8'h00, 1'b0, 1'b1);
        repeat (40) send_tick(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        set_half_period(16'd2);
        finish_command(-1, 0);
        set_half_period(16'd1);

        k = 0;
        base = sb.requests;
        while (sb.requests - base < 500 || k < 3) begin
            if (k == 0) quiet <= 1'b1;
            if (k == 2) quiet <= 1'b0;
            if (k == 2) stall_go <= ~stall_go;
            if (k == 20) set_half_period(16'd1);
            if ($urandom_range(0, 99) < 15) begin
                run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), -1, 20);
            end else begin
                run_command(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            -1, 3);
                repeat ($urandom_range(1, 4))
                    run_command($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), -1, 3);
                if ($urandom_range(0, 9) != 0)
                    run_command(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                -1, 3);
            end
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 5))
                    0: set_half_period(16'd0);
                    1, 2: set_half_period(16'd1);
                    3: set_half_period(16'd2);
                    4: set_half_period(16'd3);
                    default: set_half_period(16'($urandom_range(4, 6)));
                endcase
            end
            k++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Covered %0d requests with %0d results checked: %0d commands finished, %0d rejected,",
                 sb.requests, sb.checked, sb.finished, sb.rejects);
        $display("over %0d phase-length settings including 0 and 65535, with a long receiver stall.",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("i2c_master_byte_engine_top regression: pass");
        end else begin
            $display("i2c_master_byte_engine_top regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/i2cme_pkg.sv
rtl/core/i2cme_step.sv
rtl/core/i2c_master_byte_engine_top.sv
verif/testbench.sv
